[design/rsd_pkg.sv]
// rsd_pkg: shared types, constants and saturating helpers for the
// route sequence schedule decoder; no dependencies
package rsd_pkg;

  localparam int SITE_W   = 6;
  localparam int TIME_W   = 16;
  localparam int MIN_W    = 20;
  localparam int DAY_W    = 6;
  localparam int LOSS_W   = 48;
  localparam int MAX_SITES = 64;
  localparam int TRAV_AW  = 2 * SITE_W;
  localparam int PROD_W   = 37;
  localparam int SPAN_W   = 21;
  localparam int NEED_W   = 22;

  localparam logic [10:0]       DAY_MINUTES = 11'd1440;
  localparam logic [DAY_W-1:0]  DAY_MAX     = '1;
  localparam logic [MIN_W-1:0]  MINUTE_MAX  = '1;
  localparam logic [LOSS_W-1:0] LOSS_MAX    = '1;
  localparam logic [LOSS_W-1:0] LOSS_INIT   = 48'd1;

  typedef enum logic [1:0] {
    REQ_TRAVEL = 2'd0,
    REQ_CLIENT = 2'd1,
    REQ_LIMIT  = 2'd2,
    REQ_SEQ    = 2'd3
  } req_t;

  typedef struct packed {
    req_t              kind;
    logic [SITE_W-1:0] site_a;
    logic [SITE_W-1:0] site_b;
    logic [TIME_W-1:0] travel;
    logic [TIME_W-1:0] work;
    logic [TIME_W-1:0] prio;
    logic [TIME_W-1:0] limit;
    logic [SITE_W-1:0] elem;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              is_visit;
    logic [SITE_W-1:0] worker;
    logic [SITE_W-1:0] client;
    logic [DAY_W-1:0]  day;
    logic [MIN_W-1:0]  start;
    logic [LOSS_W-1:0] loss;
    logic              done;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HOME, ST_GO, ST_BACK, ST_REGO, ST_REGOT,
    ST_ADV, ST_MUL, ST_POST, ST_LAST, ST_LASTD, ST_EMIT
  } state_t;

  function automatic logic [LOSS_W-1:0] loss_add(input logic [LOSS_W-1:0] acc,
                                                 input logic [PROD_W-1:0] v);
    logic [LOSS_W:0] s;
    s = {1'b0, acc} + {{(LOSS_W+1-PROD_W){1'b0}}, v};
    if (s >= {1'b0, LOSS_MAX}) return LOSS_MAX;
    return s[LOSS_W-1:0];
  endfunction

  function automatic logic [MIN_W-1:0] min_add(input logic [MIN_W-1:0] m,
                                               input logic [TIME_W-1:0] v);
    logic [MIN_W:0] s;
    s = {1'b0, m} + {{(MIN_W+1-TIME_W){1'b0}}, v};
    if (s[MIN_W]) return MINUTE_MAX;
    return s[MIN_W-1:0];
  endfunction

endpackage

[design/route_sequence_schedule_decoder.sv]
// a worker switch element passes the idle, home and emit states into the result
// queue, a client visit idle, home, go, back, rego and regot on a new day, adv, mul, post
// and emit, a last element adds last and lastd before emit; the back end takes one item
// at a time and holds in its emit state while the two-entry result queue is full
// reset: synchronous active-low rst_n clears queues, walk state and worker_total to 1;
// tables hold no reset value and must be written before use
module route_sequence_schedule_decoder import rsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_req_type,
  input  logic [SITE_W-1:0] in_site_a,
  input  logic [SITE_W-1:0] in_site_b,
  input  logic [TIME_W-1:0] in_travel_minutes,
  input  logic [TIME_W-1:0] in_work_minutes,
  input  logic [TIME_W-1:0] in_visit_priority,
  input  logic [TIME_W-1:0] in_limit_minutes,
  input  logic [SITE_W-1:0] in_order_element,
  input  logic              in_last,
  output logic              empty,
  input  logic              pop,
  output logic              out_is_visit,
  output logic [SITE_W-1:0] out_worker_id,
  output logic [SITE_W-1:0] out_client_id,
  output logic [DAY_W-1:0]  out_day_index,
  output logic [MIN_W-1:0]  out_start_minute,
  output logic [LOSS_W-1:0] out_loss_total,
  output logic              out_done_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SITE_W-1:0] cfg_worker_total
);

  logic [SITE_W-1:0] wt_r;
  logic              head_valid, head_pop;
  item_t             head;
  res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r <= 6'd1;
    end else if (cfg_valid && cfg_ready) begin
      wt_r <= cfg_worker_total;
    end
  end

  rsd_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_req_type(in_req_type), .in_site_a(in_site_a), .in_site_b(in_site_b),
    .in_travel_minutes(in_travel_minutes), .in_work_minutes(in_work_minutes),
    .in_visit_priority(in_visit_priority), .in_limit_minutes(in_limit_minutes),
    .in_order_element(in_order_element), .in_last(in_last),
    .head_valid(head_valid), .head(head), .head_pop(head_pop));

  rsd_back u_back (
    .clk(clk), .rst_n(rst_n), .worker_total(wt_r),
    .head_valid(head_valid), .head(head), .head_pop(head_pop),
    .empty(empty), .pop(pop), .res(res));

  assign out_is_visit     = res.is_visit;
  assign out_worker_id    = res.worker;
  assign out_client_id    = res.client;
  assign out_day_index    = res.day;
  assign out_start_minute = res.start;
  assign out_loss_total   = res.loss;
  assign out_done_res     = res.done;

endmodule

[design/rsd_ram.sv]
// rsd_ram: generic single-write, single-read ram with registered read
// no dependencies
module rsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[design/rsd_front.sv]
// rsd_front: input side, packs items into a two-entry queue
// depends on rsd_pkg
module rsd_front import rsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_req_type,
  input  logic [SITE_W-1:0] in_site_a,
  input  logic [SITE_W-1:0] in_site_b,
  input  logic [TIME_W-1:0] in_travel_minutes,
  input  logic [TIME_W-1:0] in_work_minutes,
  input  logic [TIME_W-1:0] in_visit_priority,
  input  logic [TIME_W-1:0] in_limit_minutes,
  input  logic [SITE_W-1:0] in_order_element,
  input  logic              in_last,
  output logic              head_valid,
  output item_t             head,
  input  logic              head_pop
);

  item_t       q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  item_t       item;
  logic        wr, rd;

  always_comb begin
    item.kind   = req_t'(in_req_type);
    item.site_a = in_site_a;
    item.site_b = in_site_b;
    item.travel = in_travel_minutes;
    item.work   = in_work_minutes;
    item.prio   = in_visit_priority;
    item.limit  = in_limit_minutes;
    item.elem   = in_order_element;
    item.last   = in_last;
  end

  assign full       = cnt_r[1];
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rp_r];
  assign wr         = push && !full;
  assign rd         = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[design/rsd_back.sv]
// rsd_back: table writes and schedule sequencer with a two-entry result queue
// depends on rsd_pkg and rsd_ram
module rsd_back import rsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SITE_W-1:0] worker_total,
  input  logic              head_valid,
  input  item_t             head,
  output logic              head_pop,
  output logic              empty,
  input  logic              pop,
  output res_t              res
);

  state_t state_r, state_nxt;

  logic [SITE_W-1:0] act_r, act_nxt, cur_r, cur_nxt, site_r, site_nxt;
  logic [SITE_W-1:0] client_r, client_nxt;
  logic [DAY_W-1:0]  day_r, day_nxt, dayo_r, dayo_nxt;
  logic [MIN_W-1:0]  min_r, min_nxt, start_r, start_nxt;
  logic [LOSS_W-1:0] loss_r, loss_nxt;
  logic [TIME_W-1:0] go_r, go_nxt, work_r, work_nxt, prio_r, prio_nxt;
  logic [TIME_W-1:0] lim_r, lim_nxt, home_r, home_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              visit_r, visit_nxt, last_r, last_nxt, switch_r, switch_nxt;

  logic [TRAV_AW-1:0] t_raddr;
  logic [TIME_W-1:0]  t_rdata, w_rdata, p_rdata, l_rdata;
  logic [SITE_W-1:0]  h_site, h_client;
  logic               h_switch, newday, push_res, sel_seq;
  logic [NEED_W-1:0]  need;
  logic [SPAN_W-1:0]  span;

  res_t       oq_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  res_t       res_in;

  assign h_site   = head.elem + 6'd1;
  assign h_switch = h_site < worker_total;
  assign h_client = h_site - worker_total;
  assign sel_seq  = head.kind == REQ_SEQ;

  always_comb begin
    unique case (state_r)
      ST_IDLE:         t_raddr = {cur_r, act_r};
      ST_HOME, ST_REGO: t_raddr = {cur_r, site_r};
      ST_GO:           t_raddr = {site_r, act_r};
      default:         t_raddr = {cur_r, act_r};
    endcase
  end

  rsd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SITES * MAX_SITES)) u_travel (
    .clk(clk), .we(state_r == ST_IDLE && head_valid && head.kind == REQ_TRAVEL),
    .waddr({head.site_a, head.site_b}), .wdata(head.travel),
    .raddr(t_raddr), .rdata(t_rdata));

  rsd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SITES)) u_work (
    .clk(clk), .we(state_r == ST_IDLE && head_valid && head.kind == REQ_CLIENT),
    .waddr(head.site_a), .wdata(head.work), .raddr(h_client), .rdata(w_rdata));

  rsd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SITES)) u_prio (
    .clk(clk), .we(state_r == ST_IDLE && head_valid && head.kind == REQ_CLIENT),
    .waddr(head.site_a), .wdata(head.prio), .raddr(h_client), .rdata(p_rdata));

  rsd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SITES)) u_limit (
    .clk(clk), .we(state_r == ST_IDLE && head_valid && head.kind == REQ_LIMIT),
    .waddr(head.site_a), .wdata(head.limit), .raddr(act_r), .rdata(l_rdata));

  assign need = {2'b0, min_r} + {6'b0, go_r} + {6'b0, work_r} + {6'b0, t_rdata};
  assign newday = (min_r != '0) && (need > {6'b0, lim_r});
  assign span = {1'b0, min_r} + SPAN_W'(day_r) * SPAN_W'(DAY_MINUTES);
  assign push_res = (state_r == ST_EMIT) && !ocnt_r[1];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (head_valid && sel_seq) state_nxt = ST_HOME;
      ST_HOME:  if (switch_r) state_nxt = last_r ? ST_LAST : ST_EMIT;
                else state_nxt = ST_GO;
      ST_GO:    state_nxt = ST_BACK;
      ST_BACK:  state_nxt = newday ? ST_REGO : ST_ADV;
      ST_REGO:  state_nxt = ST_REGOT;
      ST_REGOT: state_nxt = ST_ADV;
      ST_ADV:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_POST;
      ST_POST:  state_nxt = last_r ? ST_LAST : ST_EMIT;
      ST_LAST:  state_nxt = ST_LASTD;
      ST_LASTD: state_nxt = ST_EMIT;
      ST_EMIT:  if (!ocnt_r[1]) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    act_nxt = act_r;  cur_nxt = cur_r;  site_nxt = site_r;  client_nxt = client_r;
    day_nxt = day_r;  dayo_nxt = dayo_r;  min_nxt = min_r;  start_nxt = start_r;
    loss_nxt = loss_r;  go_nxt = go_r;  work_nxt = work_r;  prio_nxt = prio_r;
    lim_nxt = lim_r;  home_nxt = home_r;  prod_nxt = prod_r;
    visit_nxt = visit_r;  last_nxt = last_r;  switch_nxt = switch_r;
    head_pop = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        head_pop = head_valid;
        if (head_valid && sel_seq) begin
          site_nxt   = h_site;
          switch_nxt = h_switch;
          visit_nxt  = !h_switch;
          client_nxt = h_switch ? '0 : h_client;
          last_nxt   = head.last;
          start_nxt  = '0;
          dayo_nxt   = '0;
        end
      end
      ST_HOME: begin
        home_nxt = t_rdata;
        work_nxt = w_rdata;
        prio_nxt = p_rdata;
        lim_nxt  = l_rdata;
        if (switch_r) begin
          loss_nxt = loss_add(loss_r, PROD_W'(t_rdata));
          act_nxt  = site_r;
          cur_nxt  = site_r;
          day_nxt  = '0;
          min_nxt  = '0;
        end
      end
      ST_GO: go_nxt = t_rdata;
      ST_BACK: begin
        if (newday) begin
          loss_nxt = loss_add(loss_r, PROD_W'(home_r));
          cur_nxt  = act_r;
          if (day_r != DAY_MAX) day_nxt = day_r + 6'd1;
          min_nxt  = '0;
        end
      end
      ST_REGOT: go_nxt = t_rdata;
      ST_ADV: begin
        loss_nxt = loss_add(loss_r, PROD_W'(go_r));
        min_nxt  = min_add(min_r, go_r);
      end
      ST_MUL: prod_nxt = PROD_W'(prio_r) * PROD_W'(span);
      ST_POST: begin
        loss_nxt  = loss_add(loss_r, prod_r);
        start_nxt = min_r;
        dayo_nxt  = day_r;
        min_nxt   = min_add(min_r, work_r);
        cur_nxt   = site_r;
      end
      ST_LASTD: loss_nxt = loss_add(loss_r, PROD_W'(t_rdata));
      ST_EMIT: begin
        if (!ocnt_r[1] && last_r) begin
          act_nxt  = '0;
          cur_nxt  = '0;
          day_nxt  = '0;
          min_nxt  = '0;
          loss_nxt = LOSS_INIT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r   <= '0;
      cur_r   <= '0;
      day_r   <= '0;
      min_r   <= '0;
      loss_r  <= LOSS_INIT;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      cur_r   <= cur_nxt;
      day_r   <= day_nxt;
      min_r   <= min_nxt;
      loss_r  <= loss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    site_r <= site_nxt;  client_r <= client_nxt;  dayo_r <= dayo_nxt;
    start_r <= start_nxt;  go_r <= go_nxt;  work_r <= work_nxt;  prio_r <= prio_nxt;
    lim_r <= lim_nxt;  home_r <= home_nxt;  prod_r <= prod_nxt;
    visit_r <= visit_nxt;  last_r <= last_nxt;  switch_r <= switch_nxt;
  end

  // result queue
  always_comb begin
    res_in.is_visit = visit_r;
    res_in.worker   = act_r;
    res_in.client   = client_r;
    res_in.day      = dayo_r;
    res_in.start    = start_r;
    res_in.loss     = loss_r;
    res_in.done     = last_r;
  end

  assign empty = (ocnt_r == 2'd0);
  assign res   = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (push_res) begin
      oq_r[owp_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (push_res) owp_r <= !owp_r;
      if (pop && !empty) orp_r <= !orp_r;
      ocnt_r <= ocnt_r + {1'b0, push_res} - {1'b0, pop && !empty};
    end
  end

endmodule
